[design/ats_pkg.sv]
// shared types and constants for the aligned transfer splitter
// no dependencies
`timescale 1ns / 1ps

package ats_pkg;

   localparam int MAX_BYTES   = 64;
   localparam int CNT_W       = 7;
   localparam int OFS_W       = 16;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam logic       OP_COPY = 1'b0;
   localparam logic       OP_FILL = 1'b1;

   localparam logic [1:0] WC_1B = 2'd0;
   localparam logic [1:0] WC_2B = 2'd1;
   localparam logic [1:0] WC_4B = 2'd2;
   localparam logic [1:0] WC_8B = 2'd3;

   typedef struct packed {
      logic                    op;
      logic signed [OFS_W-1:0] dst_offset;
      logic signed [OFS_W-1:0] src_offset;
      logic [CNT_W-1:0]        byte_count;
   } req_type;

   typedef struct packed {
      logic [1:0]              width_code;
      logic signed [OFS_W-1:0] chunk_dst;
      logic signed [OFS_W-1:0] chunk_src;
      logic                    last;
   } rsp_type;

   typedef struct packed {
      logic             fill;
      logic [OFS_W-1:0] dst;
      logic [OFS_W-1:0] src;
      logic [CNT_W-1:0] count;
   } job_type;

endpackage

[design/ats_front.sv]
// request intake: saturates the count, drops zero-count and self-copy requests, builds jobs
// depends on ats_pkg
`timescale 1ns / 1ps

module ats_front import ats_pkg::*; (
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   input  logic    job_ready,
   output logic    job_valid,
   output job_type job_data
);

   logic             fill;
   logic [CNT_W-1:0] count_sat;
   logic             useful;

   always_comb begin
      fill      = (req_data.op == OP_FILL);
      count_sat = (req_data.byte_count > CNT_W'(MAX_BYTES)) ? CNT_W'(MAX_BYTES)
                                                            : req_data.byte_count;
      useful    = (count_sat != '0) &&
                  (fill || (req_data.dst_offset != req_data.src_offset));
      job_data.fill  = fill;
      job_data.dst   = req_data.dst_offset;
      job_data.src   = fill ? '0 : req_data.src_offset;
      job_data.count = count_sat;
   end

   // empty requests are taken and dropped
   assign req_ready = job_ready;
   assign job_valid = req_valid && useful;

endmodule

[design/ats_queue.sv]
// short job queue between intake and chunk sequencer
// depends on ats_pkg
`timescale 1ns / 1ps

module ats_queue import ats_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  job_type push_data,
   output logic    pop_valid,
   input  logic    pop_ready,
   output job_type pop_data
);

   job_type             entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]   count_ff, count_in;
   logic                push, pop;

   assign push_ready = (count_ff != (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QUEUE_AW+1)'(QUEUE_DEPTH))
      else $error("queue count above depth");
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("empty queue with pointers apart");
   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("pop did not lower count");
`endif

endmodule

[design/ats_back.sv]
// chunk sequencer: walks one job, one chunk a beat while the output register can take it, into that register
// depends on ats_pkg
`timescale 1ns / 1ps

module ats_back import ats_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    job_valid,
   output logic    job_ready,
   input  job_type job_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic             busy_ff, busy_in;
   logic             fill_ff;
   logic [OFS_W-1:0] dst_ff, src_ff;
   logic [CNT_W-1:0] left_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff;

   logic             step, load;
   logic [2:0]       align;
   logic [1:0]       code;
   logic [CNT_W-1:0] width_bytes;
   logic [CNT_W-1:0] left_rem;

   assign job_ready = !busy_ff;
   assign load      = job_valid && job_ready;
   assign step      = busy_ff && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      align = fill_ff ? dst_ff[2:0] : (dst_ff[2:0] | src_ff[2:0]);
      if (left_ff >= CNT_W'(8) && align == 3'd0) begin
         code = WC_8B;
      end else if (left_ff >= CNT_W'(4) && align[1:0] == 2'd0) begin
         code = WC_4B;
      end else if (left_ff >= CNT_W'(2) && !align[0]) begin
         code = WC_2B;
      end else begin
         code = WC_1B;
      end
      width_bytes = CNT_W'(1) << code;
      left_rem    = left_ff - width_bytes;

      busy_in      = busy_ff;
      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         busy_in      = (left_rem != '0);
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load) begin
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         fill_ff <= job_data.fill;
         dst_ff  <= job_data.dst;
         src_ff  <= job_data.src;
         left_ff <= job_data.count;
      end else if (step) begin
         dst_ff  <= dst_ff + OFS_W'(width_bytes);
         src_ff  <= fill_ff ? src_ff : src_ff + OFS_W'(width_bytes);
         left_ff <= left_rem;
      end
      if (step) begin
         rsp_data_ff.width_code <= code;
         rsp_data_ff.chunk_dst  <= dst_ff;
         rsp_data_ff.chunk_src  <= src_ff;
         rsp_data_ff.last       <= (left_rem == '0);
      end
   end

`ifndef SYNTH
   a_left_nonzero: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (left_ff != '0))
      else $error("active job with nothing left");
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (width_bytes <= left_ff))
      else $error("chunk wider than remaining count");
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (step && left_rem == '0) |=> !busy_ff)
      else $error("job still active after last chunk");
   a_step_shows: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid_ff)
      else $error("chunk produced but not presented");
`endif

endmodule

[design/aligned_transfer_splitter_top.sv]
// top level of the aligned transfer splitter
// depends on ats_pkg, ats_front, ats_queue, ats_back
`timescale 1ns / 1ps

// Splits a copy or zero-fill request into chunks of 8, 4, 2 or 1 bytes, the
// widest that the remaining count and the offset alignment allow; a zero
// count or a copy onto itself gives no beats. The chunk sequencer emits one
// chunk a cycle into an output register while that register is empty or
// rsp_ready is high. Requests are taken into a two-deep job queue while an
// earlier request is still being split, so intake stalls only when the queue
// is full.

module aligned_transfer_splitter_top import ats_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    front_valid, front_ready;
   job_type front_job;
   logic    back_valid, back_ready;
   job_type back_job;

   ats_front u_front (
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .job_ready (front_ready),
      .job_valid (front_valid),
      .job_data  (front_job)
   );

   ats_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_data  (front_job),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_data   (back_job)
   );

   ats_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (back_valid),
      .job_ready (back_ready),
      .job_data  (back_job),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
